FILE: rtl/sme_pkg.sv
// shared types and constants for the stereo multi-tap echo
// used by sme_mac and stereo_multi_tap_echo; depends on nothing

package sme_pkg;

  localparam int SAMPLE_W = 16;
  localparam int DELAY_W  = 14;
  localparam int GAIN_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam int MAC_A_W  = 19;
  localparam int MAC_B_W  = 16;
  localparam int PROD_W   = MAC_A_W + MAC_B_W + 1;
  localparam int ACC_W    = 54;
  localparam int TAPSUM_W = 36;
  localparam int LO_W     = 18;
  localparam int FRAC_W   = 30;
  localparam int DRY_SHIFT = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY_SAMPLES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WET_GAIN      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DRY_GAIN      = 2'd2;

  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) <<< (FRAC_W - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(32768);

  // q0.16 weight of tap k+1, about 1/(k+2), halves rounded up
  localparam logic [MAC_B_W-1:0] TAP_WEIGHT [16] = '{
    16'd32768, 16'd21845, 16'd16384, 16'd13107,
    16'd10923, 16'd9362,  16'd8192,  16'd7282,
    16'd6554,  16'd5958,  16'd5461,  16'd5041,
    16'd4681,  16'd4369,  16'd4096,  16'd3855
  };

  typedef enum logic [1:0] {
    SHIFT_NONE,
    SHIFT_DRY,
    SHIFT_HI
  } shift_sel_t;

  typedef struct packed {
    logic                       valid;
    logic                       clear;
    shift_sel_t                 shift;
    logic signed [MAC_A_W-1:0]  a;
    logic [MAC_B_W-1:0]         b;
  } mac_op_t;

endpackage

FILE: rtl/sme_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies

module sme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/sme_mac.sv
// shared multiply-accumulate unit: registered product, then shifted accumulate
// depends on sme_pkg

module sme_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  sme_pkg::mac_op_t                    op,
  output logic signed [sme_pkg::ACC_W-1:0]    acc,
  output logic                                busy
);

  logic signed [sme_pkg::PROD_W-1:0] prod;
  logic                              p_clear;
  sme_pkg::shift_sel_t               p_shift;
  logic signed [sme_pkg::ACC_W-1:0]  pext;
  logic signed [sme_pkg::ACC_W-1:0]  addend;
  logic signed [sme_pkg::ACC_W-1:0]  base;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= op.valid;
    end
    prod    <= op.a * $signed({1'b0, op.b});
    p_clear <= op.clear;
    p_shift <= op.shift;
    if (busy) begin
      acc <= base + addend;
    end
  end

  always_comb begin
    pext = sme_pkg::ACC_W'(prod);
    base = p_clear ? '0 : acc;
    case (p_shift)
      sme_pkg::SHIFT_DRY: addend = pext <<< sme_pkg::DRY_SHIFT;
      sme_pkg::SHIFT_HI:  addend = pext <<< sme_pkg::LO_W;
      default:            addend = pext;
    endcase
  end

endmodule

FILE: rtl/stereo_multi_tap_echo.sv
// stereo multi-tap echo top level: sequencer, history memories, shared mac
// depends on sme_pkg, sme_ram and sme_mac
//
// usage: one stereo pair is taken per transfer on the sample channel
// (sample_valid, sample_stall, left_sample, right_sample). the pair is written
// into the two history memories, then TAP_COUNT taps spaced delay_samples
// apart are read one per cycle and weighted through a single shared
// multiply-accumulate unit, left channel first, then right. wet and dry gains
// are applied by the same unit, and the sum is rounded and saturated.
// a delay_samples of HISTORY_DEPTH or more is first reduced by repeated
// subtraction of HISTORY_DEPTH. the shared mac and the single read port of the
// histories set how long a pair takes. sample_stall stays high after a
// transfer until result_valid rises, so one pair is in flight; the next pair
// can be taken in the cycle that result_valid rises.
// the result sits in an output register until taken; while result_stall is
// high the next pair may still be accepted, and it waits at its end for the
// register to free up. configuration writes are always ready (cfg_ready).
// reset clears the pointer and the control and config registers; history
// entries not yet written read as zero by fill tracking: no clearing pass.

module stereo_multi_tap_echo #(
  parameter int HISTORY_DEPTH = 131072,
  parameter int TAP_COUNT     = 9
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   sample_valid,
  output logic                                   sample_stall,
  input  logic signed [sme_pkg::SAMPLE_W-1:0]    left_sample,
  input  logic signed [sme_pkg::SAMPLE_W-1:0]    right_sample,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic signed [sme_pkg::SAMPLE_W-1:0]    left_out,
  output logic signed [sme_pkg::SAMPLE_W-1:0]    right_out,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [sme_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [sme_pkg::GAIN_W-1:0]             cfg_data
);

  localparam int PTR_W = $clog2(HISTORY_DEPTH);
  localparam int TAP_W = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
  localparam int CMP_W = PTR_W + sme_pkg::DELAY_W;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_REDUCE = 9'b000000010,
    S_TAP    = 9'b000000100,
    S_DRAIN  = 9'b000001000,
    S_WET_HI = 9'b000010000,
    S_WET_LO = 9'b000100000,
    S_DRY    = 9'b001000000,
    S_SETTLE = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state, state_next;

  logic [sme_pkg::DELAY_W-1:0] delay_samples;
  logic [sme_pkg::GAIN_W-1:0]  wet_gain;
  logic [sme_pkg::GAIN_W-1:0]  dry_gain;

  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] wp_next;
  logic             wrapped;
  logic [PTR_W-1:0] loc;
  logic [PTR_W-1:0] loc_rd;
  logic [sme_pkg::DELAY_W-1:0] dm;
  logic [TAP_W-1:0] tap;
  logic             ch;

  logic signed [sme_pkg::SAMPLE_W-1:0] left_in;
  logic signed [sme_pkg::SAMPLE_W-1:0] right_in;
  logic signed [sme_pkg::SAMPLE_W-1:0] left_hold;
  logic signed [sme_pkg::TAPSUM_W-1:0] tapsum;

  logic             rd_pend;
  logic             rd_first;
  logic             rd_ok;
  logic [TAP_W-1:0] rd_idx;
  logic [sme_pkg::SAMPLE_W-1:0] rdata_l;
  logic [sme_pkg::SAMPLE_W-1:0] rdata_r;

  sme_pkg::mac_op_t                 op;
  logic signed [sme_pkg::ACC_W-1:0] acc;
  logic                             mac_busy;

  logic signed [sme_pkg::ACC_W-1:0]    rnd;
  logic signed [sme_pkg::SAMPLE_W-1:0] sat;
  logic signed [sme_pkg::SAMPLE_W-1:0] dry_s;
  logic signed [sme_pkg::SAMPLE_W-1:0] tap_s;

  logic take;
  logic slot_free;
  logic dm_big;
  logic tap_last;
  logic loc_ge;
  logic [PTR_W:0] dm_p;
  logic [PTR_W:0] depth_p;

  assign cfg_ready    = 1'b1;
  assign sample_stall = (state != S_IDLE);
  assign take         = sample_valid && !sample_stall;
  assign slot_free    = !result_valid || !result_stall;

  assign wp_next = (wp == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : wp + 1'b1;
  assign dm_big  = CMP_W'(dm) >= CMP_W'(HISTORY_DEPTH);
  assign tap_last = (tap == TAP_W'(TAP_COUNT - 1));

  // step back one tap spacing, wrapping around the history
  assign dm_p    = (PTR_W + 1)'(dm);
  assign depth_p = (PTR_W + 1)'(HISTORY_DEPTH);
  assign loc_ge  = {1'b0, loc} >= dm_p;
  always_comb begin
    if (loc_ge) begin
      loc_rd = PTR_W'({1'b0, loc} - dm_p);
    end else begin
      loc_rd = PTR_W'({1'b0, loc} + depth_p - dm_p);
    end
  end

  sme_ram #(.WIDTH(sme_pkg::SAMPLE_W), .DEPTH(HISTORY_DEPTH)) u_left_hist (
    .clk   (clk),
    .we    (take),
    .waddr (wp_next),
    .wdata (left_sample),
    .raddr (loc_rd),
    .rdata (rdata_l)
  );

  sme_ram #(.WIDTH(sme_pkg::SAMPLE_W), .DEPTH(HISTORY_DEPTH)) u_right_hist (
    .clk   (clk),
    .we    (take),
    .waddr (wp_next),
    .wdata (right_sample),
    .raddr (loc_rd),
    .rdata (rdata_r)
  );

  sme_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .op   (op),
    .acc  (acc),
    .busy (mac_busy)
  );

  // mac operand selection
  always_comb begin
    tap_s = rd_ok ? signed'(ch ? rdata_r : rdata_l) : '0;
    dry_s = ch ? right_in : left_in;
    op.valid = 1'b0;
    op.clear = 1'b0;
    op.shift = sme_pkg::SHIFT_NONE;
    op.a     = sme_pkg::MAC_A_W'(tap_s);
    op.b     = sme_pkg::TAP_WEIGHT[4'(rd_idx)];
    if (rd_pend) begin
      op.valid = 1'b1;
      op.clear = rd_first;
    end else begin
      case (state)
        S_WET_HI: begin
          op.valid = 1'b1;
          op.clear = 1'b1;
          op.shift = sme_pkg::SHIFT_HI;
          op.a     = sme_pkg::MAC_A_W'($signed(tapsum[sme_pkg::TAPSUM_W-1:sme_pkg::LO_W]));
          op.b     = wet_gain;
        end
        S_WET_LO: begin
          op.valid = 1'b1;
          op.a     = {1'b0, tapsum[sme_pkg::LO_W-1:0]};
          op.b     = wet_gain;
        end
        S_DRY: begin
          op.valid = 1'b1;
          op.shift = sme_pkg::SHIFT_DRY;
          op.a     = sme_pkg::MAC_A_W'(dry_s);
          op.b     = dry_gain;
        end
        default: begin
        end
      endcase
    end
  end

  // round to nearest, halves up, then saturate
  always_comb begin
    rnd = (acc + sme_pkg::ROUND_BIAS) >>> sme_pkg::FRAC_W;
    if (rnd > sme_pkg::SAT_HI) begin
      sat = 16'sh7fff;
    end else if (rnd < sme_pkg::SAT_LO) begin
      sat = 16'sh8000;
    end else begin
      sat = sme_pkg::SAMPLE_W'(rnd);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (take) state_next = S_REDUCE;
      S_REDUCE: if (!dm_big) state_next = S_TAP;
      S_TAP:    if (tap_last) state_next = S_DRAIN;
      S_DRAIN:  if (!rd_pend && !mac_busy) state_next = S_WET_HI;
      S_WET_HI: state_next = S_WET_LO;
      S_WET_LO: state_next = S_DRY;
      S_DRY:    state_next = S_SETTLE;
      S_SETTLE: if (!mac_busy) state_next = S_DONE;
      S_DONE: begin
        if (!ch) begin
          state_next = S_TAP;
        end else if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      delay_samples <= '0;
      wet_gain      <= '0;
      dry_gain      <= '0;
      wp            <= '0;
      wrapped       <= 1'b0;
      rd_pend       <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          sme_pkg::REG_DELAY_SAMPLES: delay_samples <= cfg_data[sme_pkg::DELAY_W-1:0];
          sme_pkg::REG_WET_GAIN:      wet_gain <= cfg_data;
          sme_pkg::REG_DRY_GAIN:      dry_gain <= cfg_data;
          default: begin
          end
        endcase
      end
      if (take) begin
        wp <= wp_next;
        if (wp_next == '0) begin
          wrapped <= 1'b1;
        end
      end
      rd_pend <= (state == S_TAP);
      if (state == S_DONE && ch && slot_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end

    // datapath registers
    if (take) begin
      left_in  <= left_sample;
      right_in <= right_sample;
      dm       <= delay_samples;
    end
    if (state == S_REDUCE) begin
      if (dm_big) begin
        dm <= sme_pkg::DELAY_W'(CMP_W'(dm) - CMP_W'(HISTORY_DEPTH));
      end
      loc <= wp;
      tap <= '0;
      ch  <= 1'b0;
    end
    if (state == S_TAP) begin
      loc      <= loc_rd;
      tap      <= tap + 1'b1;
      rd_idx   <= tap;
      rd_first <= (tap == '0);
      rd_ok    <= wrapped || (loc_rd != '0 && loc_rd <= wp);
    end
    if (state == S_DRAIN) begin
      tapsum <= acc[sme_pkg::TAPSUM_W-1:0];
    end
    if (state == S_DONE) begin
      if (!ch) begin
        left_hold <= sat;
        ch        <= 1'b1;
        loc       <= wp;
        tap       <= '0;
      end else if (slot_free) begin
        left_out  <= left_hold;
        right_out <= sat;
      end
    end
  end

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    take |=> sample_stall)
    else $error("sample channel open right after a transfer");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!rd_pend && !mac_busy))
    else $error("mac or read pipeline active while idle");

  a_loc_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_TAP) |-> (CMP_W'(loc) < CMP_W'(HISTORY_DEPTH)))
    else $error("tap location outside history");

  a_result_once: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && ch && slot_free) |=> (state == S_IDLE && result_valid))
    else $error("finished result not presented");

endmodule

FILE: dv/sme_echo_checker.sv
// watches the sample, result and register channels of stereo_multi_tap_echo,
// predicts each stereo result and compares it with the one the block delivers
// depends on sme_pkg only
`timescale 1ns / 1ps

module sme_echo_checker #(
  parameter int HISTORY_DEPTH = 131072,
  parameter int TAP_COUNT     = 9
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  input  logic                                sample_stall,
  input  logic signed [sme_pkg::SAMPLE_W-1:0] left_sample,
  input  logic signed [sme_pkg::SAMPLE_W-1:0] right_sample,
  input  logic                                result_valid,
  input  logic                                result_stall,
  input  logic signed [sme_pkg::SAMPLE_W-1:0] left_out,
  input  logic signed [sme_pkg::SAMPLE_W-1:0] right_out,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [sme_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sme_pkg::GAIN_W-1:0]          cfg_data,
  output int                                  fail_count,
  output int                                  pending
);

  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic signed [sme_pkg::SAMPLE_W-1:0] left;
    logic signed [sme_pkg::SAMPLE_W-1:0] right;
  } stereo_pair_t;

  logic signed [sme_pkg::SAMPLE_W-1:0] left_hist [HISTORY_DEPTH];
  logic signed [sme_pkg::SAMPLE_W-1:0] right_hist [HISTORY_DEPTH];
  int unsigned                         wr_ptr;
  logic [sme_pkg::DELAY_W-1:0]         delay_reg;
  logic [sme_pkg::GAIN_W-1:0]          wet_reg;
  logic [sme_pkg::GAIN_W-1:0]          dry_reg;
  longint                              tap_weight [1:TAP_COUNT];
  stereo_pair_t                        expected_pairs [$];

  initial begin
    fail_count = 0;
    pending = 0;
    // q0.16 weight near 1/(k+1), halves rounded up
    for (int k = 1; k <= TAP_COUNT; k++) begin
      tap_weight[k] = ((131072 / (k + 1)) + 1) / 2;
    end
  end

  task automatic report(input string msg);
    if (fail_count < PRINT_LIMIT) begin
      $display("%0t: %s", $realtime, msg);
    end
    fail_count++;
  endtask

  function automatic logic signed [sme_pkg::SAMPLE_W-1:0] mix_and_saturate(
    input longint tap_sum,
    input longint dry_sample
  );
    longint total;
    longint rounded;
    total = tap_sum * longint'(wet_reg) + dry_sample * longint'(dry_reg) * 65536;
    // floor of (total + half) at scale 2^30 is round half up
    rounded = (total + (longint'(1) <<< 29)) >>> 30;
    if (rounded > 32767) begin
      rounded = 32767;
    end
    if (rounded < -32768) begin
      rounded = -32768;
    end
    return sme_pkg::SAMPLE_W'(rounded);
  endfunction

  function automatic stereo_pair_t predict_echo(
    input logic signed [sme_pkg::SAMPLE_W-1:0] l,
    input logic signed [sme_pkg::SAMPLE_W-1:0] r
  );
    longint       lsum;
    longint       rsum;
    int unsigned  back;
    int unsigned  loc;
    stereo_pair_t res;
    lsum = 0;
    rsum = 0;
    wr_ptr = (wr_ptr + 1) % HISTORY_DEPTH;
    left_hist[wr_ptr] = l;
    right_hist[wr_ptr] = r;
    for (int k = 1; k <= TAP_COUNT; k++) begin
      back = (int'(delay_reg) * k) % HISTORY_DEPTH;
      loc = (wr_ptr + HISTORY_DEPTH - back) % HISTORY_DEPTH;
      lsum += longint'(left_hist[loc]) * tap_weight[k];
      rsum += longint'(right_hist[loc]) * tap_weight[k];
    end
    res.left = mix_and_saturate(lsum, longint'(l));
    res.right = mix_and_saturate(rsum, longint'(r));
    return res;
  endfunction

  always @(posedge clk) begin : watch
    stereo_pair_t exp_pair;
    if (rst) begin
      wr_ptr = 0;
      delay_reg = '0;
      wet_reg = '0;
      dry_reg = '0;
      expected_pairs.delete();
      foreach (left_hist[a]) begin
        left_hist[a] = '0;
        right_hist[a] = '0;
      end
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_pairs.size() == 0) begin
          report($sformatf("result transfer %0d/%0d with nothing expected",
                           left_out, right_out));
        end else begin
          exp_pair = expected_pairs.pop_front();
          if (left_out !== exp_pair.left) begin
            report($sformatf("left_out expected %0d, got %0d", exp_pair.left, left_out));
          end
          if (right_out !== exp_pair.right) begin
            report($sformatf("right_out expected %0d, got %0d", exp_pair.right, right_out));
          end
        end
      end
      if (sample_valid && !sample_stall) begin
        expected_pairs.push_back(predict_echo(left_sample, right_sample));
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sme_pkg::REG_DELAY_SAMPLES: begin
            delay_reg = cfg_data[sme_pkg::DELAY_W-1:0];
          end
          sme_pkg::REG_WET_GAIN: begin
            wet_reg = cfg_data;
          end
          sme_pkg::REG_DRY_GAIN: begin
            dry_reg = cfg_data;
          end
          default: begin
          end
        endcase
      end
    end
    pending <= expected_pairs.size();
  end

endmodule

FILE: dv/stereo_multi_tap_echo_tb.sv
// top of the stereo_multi_tap_echo testbench: clock, reset, sample and register
// stimulus, result back-pressure and the verdict
// depends on sme_pkg, the block's rtl and sme_echo_checker
`timescale 1ns / 1ps

module stereo_multi_tap_echo_tb;

  localparam int HISTORY_DEPTH = 131072;
  localparam int TAP_COUNT     = 9;
  localparam int RUN_LIMIT     = 800000;
  localparam int DRAIN_CYCLES  = 80;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 200;
  localparam logic [sme_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                                clk;
  logic                                rst = 1'b1;
  logic                                sample_valid = 1'b0;
  logic                                sample_stall;
  logic signed [sme_pkg::SAMPLE_W-1:0] left_sample = '0;
  logic signed [sme_pkg::SAMPLE_W-1:0] right_sample = '0;
  logic                                result_valid;
  logic                                result_stall = 1'b0;
  logic signed [sme_pkg::SAMPLE_W-1:0] left_out;
  logic signed [sme_pkg::SAMPLE_W-1:0] right_out;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [sme_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [sme_pkg::GAIN_W-1:0]          cfg_data = '0;
  int                                  fail_count;
  int                                  pending;
  int                                  cycle_count = 0;
  int                                  burst_left = 0;
  int                                  rx_mode = 0;
  int                                  rx_left = 0;

  stereo_multi_tap_echo #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .TAP_COUNT    (TAP_COUNT)
  ) i_dut (
    .*
  );

  sme_echo_checker #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .TAP_COUNT    (TAP_COUNT)
  ) i_checker (
    .*
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result back-pressure: free-flowing, light and heavy stretches
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(20, 400);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0: begin
        result_stall <= 1'b0;
      end
      1: begin
        result_stall <= ($urandom_range(0, 2) == 0);
      end
      default: begin
        result_stall <= ($urandom_range(0, 7) != 0);
      end
    endcase
  end

  task automatic send_pair(input logic signed [sme_pkg::SAMPLE_W-1:0] l,
                           input logic signed [sme_pkg::SAMPLE_W-1:0] r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 4);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 8);
    end
    sample_valid = 1'b1;
    left_sample = l;
    right_sample = r;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    @(negedge clk);
    burst_left--;
    if (burst_left == 0) begin
      sample_valid = 1'b0;
    end
  endtask

  task automatic write_reg(input logic [sme_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sme_pkg::GAIN_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_quiet();
    sample_valid = 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_echo(input logic [sme_pkg::GAIN_W-1:0] delay,
                          input logic [sme_pkg::GAIN_W-1:0] wet,
                          input logic [sme_pkg::GAIN_W-1:0] dry);
    wait_quiet();
    write_reg(sme_pkg::REG_DELAY_SAMPLES, delay);
    write_reg(sme_pkg::REG_WET_GAIN, wet);
    write_reg(sme_pkg::REG_DRY_GAIN, dry);
  endtask

  function automatic logic [sme_pkg::GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'd16384;
      default: return sme_pkg::GAIN_W'($urandom);
    endcase
  endfunction

  function automatic logic [sme_pkg::GAIN_W-1:0] pick_delay();
    case ($urandom_range(0, 8))
      0: return 16'd0;
      1: return 16'hFFFF;
      2, 3, 4, 5: return sme_pkg::GAIN_W'($urandom_range(1, 40));
      6, 7: return sme_pkg::GAIN_W'($urandom_range(41, 180));
      default: return sme_pkg::GAIN_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [sme_pkg::SAMPLE_W-1:0] pick_sample();
    if ($urandom_range(0, 6) != 0) begin
      return sme_pkg::SAMPLE_W'($urandom);
    end
    case ($urandom_range(0, 4))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      3: return -16'sd1;
      default: return 16'sd1;
    endcase
  endfunction

  initial begin : stimulus
    logic signed [sme_pkg::SAMPLE_W-1:0] edge_vals [8];
    edge_vals = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1,
                  16'sd1, 16'sh5555, -16'sh5556, 16'sd16384};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // zero delay, both gains at the top of their range
    set_echo(16'd0, 16'hFFFF, 16'hFFFF);
    for (int n = 0; n < 8; n++) begin
      send_pair(edge_vals[n], edge_vals[7 - n]);
    end
    // unit delay, wet only
    set_echo(16'd1, 16'd16384, 16'd0);
    for (int n = 0; n < 6; n++) begin
      send_pair(edge_vals[n], -edge_vals[n]);
    end
    // write to an unknown index, then a delay with bits above its width
    wait_quiet();
    write_reg(REG_UNUSED, 16'hFFFF);
    set_echo(16'hFFFF, 16'hFFFF, 16'd1);
    for (int n = 0; n < 6; n++) begin
      send_pair(edge_vals[n + 2], edge_vals[n]);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_echo(pick_delay(), pick_gain(), pick_gain());
      if ($urandom_range(0, 3) == 0) begin
        write_reg(REG_UNUSED, sme_pkg::GAIN_W'($urandom));
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_pair(pick_sample(), pick_sample());
      end
    end

    wait_quiet();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
